// ----- rtl/core/otw_pkg.sv -----
// otw_pkg: constants, register indexes and shared types of the overlapped tile walker
// no dependencies; used by every module under rtl/core
`timescale 1ns / 1ps

package otw_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int MIN_TILE  = 64;
   localparam int DIM_W     = 13;
   localparam int POS_W     = 12;
   localparam int OV_W      = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0] TILE_RESET = DIM_W'(256);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH       = 2'd0,
      REG_IMAGE_HEIGHT      = 2'd1,
      REG_REQUESTED_TILE    = 2'd2,
      REG_REQUESTED_OVERLAP = 2'd3
   } csr_index_type;

   // clamped geometry of the walk
   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] tile;
      logic [OV_W-1:0]  overlap;
   } geom_type;

   typedef struct packed {
      logic [POS_W-1:0] core_x;
      logic [POS_W-1:0] core_y;
      logic [DIM_W-1:0] core_cols;
      logic [DIM_W-1:0] core_rows;
      logic [POS_W-1:0] ext_x;
      logic [POS_W-1:0] ext_y;
      logic [DIM_W-1:0] ext_width;
      logic [DIM_W-1:0] ext_height;
      logic             last_tile;
   } desc_type;

   typedef struct packed {
      logic emit;
      logic walk_done;
   } step_status_type;

endpackage

// ----- rtl/core/overlapped_tile_walker_unit.sv -----
// overlapped_tile_walker_unit: top level with request register, result register and checks
// depends on otw_pkg, otw_cfg and otw_step
`timescale 1ns / 1ps

// Walks the image in square tiles, row by row with x inner, one tile descriptor per
// request transaction; restart rewinds to the first tile. A request is taken every
// cycle while the result register is free or being emptied, so the sustained rate is
// one transaction per clock. A request goes through the request register, then the
// cursor update and descriptor logic that load the result register. Register writes
// reach the clamped geometry through the configuration and geometry registers, so a
// transaction may follow a write on the next cycle. A request after the last tile, or
// with a zero image side, gives no result until a restart.
module overlapped_tile_walker_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_restart,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [otw_pkg::POS_W-1:0]      rsp_core_x,
   output logic [otw_pkg::POS_W-1:0]      rsp_core_y,
   output logic [otw_pkg::DIM_W-1:0]      rsp_core_cols,
   output logic [otw_pkg::DIM_W-1:0]      rsp_core_rows,
   output logic [otw_pkg::POS_W-1:0]      rsp_ext_x,
   output logic [otw_pkg::POS_W-1:0]      rsp_ext_y,
   output logic [otw_pkg::DIM_W-1:0]      rsp_ext_width,
   output logic [otw_pkg::DIM_W-1:0]      rsp_ext_height,
   output logic                           rsp_last_tile,
   input  logic                           csr_wr_en,
   input  logic [otw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [otw_pkg::DIM_W-1:0]      csr_wdata
);

   otw_pkg::geom_type        geom;
   otw_pkg::desc_type        desc;
   otw_pkg::step_status_type status;

   logic              in_valid_ff, in_valid_in;
   logic              restart_ff, restart_in;
   logic              rsp_valid_ff, rsp_valid_in;
   otw_pkg::desc_type desc_ff, desc_in;
   logic              out_free;
   logic              fire;
   logic              req_take;

   otw_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   otw_step u_step (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .restart (restart_ff),
      .geom    (geom),
      .desc    (desc),
      .status  (status)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      fire      = in_valid_ff && out_free;
      req_ready = !in_valid_ff || out_free;
      req_take  = req_valid && req_ready;

      in_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      restart_in  = req_take ? req_restart : restart_ff;

      rsp_valid_in = rsp_valid_ff;
      desc_in      = desc_ff;
      if (fire) begin
         rsp_valid_in = status.emit;
         if (status.emit) begin
            desc_in = desc;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      restart_ff <= restart_in;
      desc_ff    <= desc_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_core_x      = desc_ff.core_x;
   assign rsp_core_y      = desc_ff.core_y;
   assign rsp_core_cols   = desc_ff.core_cols;
   assign rsp_core_rows   = desc_ff.core_rows;
   assign rsp_ext_x       = desc_ff.ext_x;
   assign rsp_ext_y       = desc_ff.ext_y;
   assign rsp_ext_width   = desc_ff.ext_width;
   assign rsp_ext_height  = desc_ff.ext_height;
   assign rsp_last_tile   = desc_ff.last_tile;

`ifndef ASSERT_OFF
   // a pending last tile means the walk has ended
   a_last_ends_walk : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && desc_ff.last_tile |-> status.walk_done)
      else $error("last tile pending while walk still active");

   // the expanded rectangle always contains the core rectangle
   a_ext_covers_core : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (desc_ff.ext_x <= desc_ff.core_x) &&
                       (desc_ff.ext_y <= desc_ff.core_y) &&
                       ({2'b0, desc_ff.ext_x} + {1'b0, desc_ff.ext_width} >=
                        {2'b0, desc_ff.core_x} + {1'b0, desc_ff.core_cols}) &&
                       ({2'b0, desc_ff.ext_y} + {1'b0, desc_ff.ext_height} >=
                        {2'b0, desc_ff.core_y} + {1'b0, desc_ff.core_rows}))
      else $error("expanded tile does not cover core tile");

   // no empty tile is ever emitted
   a_core_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (desc_ff.core_cols != '0) && (desc_ff.core_rows != '0))
      else $error("tile with zero side emitted");
`endif

endmodule

// ----- rtl/core/otw_cfg.sv -----
// otw_cfg: configuration registers and the clamped tile geometry derived from them
// depends on otw_pkg
`timescale 1ns / 1ps

module otw_cfg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [otw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [otw_pkg::DIM_W-1:0]      csr_wdata,
   output otw_pkg::geom_type              geom
);

   logic [otw_pkg::DIM_W-1:0] width_ff, width_in;
   logic [otw_pkg::DIM_W-1:0] height_ff, height_in;
   logic [otw_pkg::DIM_W-1:0] req_tile_ff, req_tile_in;
   logic [otw_pkg::DIM_W-1:0] req_ov_ff, req_ov_in;
   otw_pkg::geom_type         geom_ff, geom_in;

   logic [otw_pkg::DIM_W-1:0] w_clamp;
   logic [otw_pkg::DIM_W-1:0] h_clamp;
   logic [otw_pkg::DIM_W-1:0] big;
   logic [otw_pkg::DIM_W-1:0] tile_floor;
   logic [otw_pkg::DIM_W-1:0] tile;
   logic [otw_pkg::DIM_W-1:0] half_tile;
   logic [otw_pkg::DIM_W-1:0] ov;

   localparam logic [otw_pkg::DIM_W-1:0] MAX_D = otw_pkg::DIM_W'(otw_pkg::MAX_DIM);
   localparam logic [otw_pkg::DIM_W-1:0] MIN_T = otw_pkg::DIM_W'(otw_pkg::MIN_TILE);

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      req_tile_in = req_tile_ff;
      req_ov_in   = req_ov_ff;
      if (csr_wr_en) begin
         unique case (otw_pkg::csr_index_type'(csr_index))
            otw_pkg::REG_IMAGE_WIDTH:       width_in    = csr_wdata;
            otw_pkg::REG_IMAGE_HEIGHT:      height_in   = csr_wdata;
            otw_pkg::REG_REQUESTED_TILE:    req_tile_in = csr_wdata;
            otw_pkg::REG_REQUESTED_OVERLAP: req_ov_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp chain
   always_comb begin
      w_clamp    = (width_ff > MAX_D) ? MAX_D : width_ff;
      h_clamp    = (height_ff > MAX_D) ? MAX_D : height_ff;
      big        = (w_clamp > h_clamp) ? w_clamp : h_clamp;
      tile_floor = (req_tile_ff > MIN_T) ? req_tile_ff : MIN_T;
      if (big < MIN_T) begin
         tile = big;
      end else begin
         tile = (tile_floor < big) ? tile_floor : big;
      end
      half_tile = tile >> 1;
      ov        = (req_ov_ff < half_tile) ? req_ov_ff : half_tile;

      geom_in.width   = w_clamp;
      geom_in.height  = h_clamp;
      geom_in.tile    = tile;
      geom_in.overlap = ov[otw_pkg::OV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= '0;
         height_ff   <= '0;
         req_tile_ff <= otw_pkg::TILE_RESET;
         req_ov_ff   <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         req_tile_ff <= req_tile_in;
         req_ov_ff   <= req_ov_in;
      end
      geom_ff <= geom_in;
   end

   assign geom = geom_ff;

endmodule

// ----- rtl/core/otw_step.sv -----
// otw_step: tile cursor state and the descriptor of the tile it points at
// depends on otw_pkg; geometry comes from otw_cfg
`timescale 1ns / 1ps

module otw_step (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic                        restart,
   input  otw_pkg::geom_type           geom,
   output otw_pkg::desc_type           desc,
   output otw_pkg::step_status_type    status
);

   localparam int DW = otw_pkg::DIM_W;

   logic [DW-1:0] col_ff, col_in;
   logic [DW-1:0] row_ff, row_in;
   logic          done_ff, done_in;

   logic [DW-1:0] col0, row0;
   logic          done0;
   logic          empty;
   logic          wrap;
   logic [DW:0]   row_wrap;
   logic [DW:0]   row1;
   logic          end_walk;
   logic          emit;
   logic [DW-1:0] x, y;
   logic [DW-1:0] ov;
   logic [DW-1:0] rem_w, rem_h;
   logic [DW-1:0] cw, ch;
   logic [DW-1:0] ex, ey;
   logic [DW:0]   er_sum, eb_sum;
   logic [DW-1:0] er, eb;
   logic [DW:0]   nxt_col, nxt_row;
   logic          next_wrap;
   logic          last;

   always_comb begin
      col0  = restart ? '0 : col_ff;
      row0  = restart ? '0 : row_ff;
      done0 = restart ? 1'b0 : done_ff;
      empty = (geom.width == '0) || (geom.height == '0);

      // column cursor beyond the image: start of the next row
      wrap     = col0 >= geom.width;
      row_wrap = {1'b0, row0} + {1'b0, geom.tile};
      row1     = wrap ? row_wrap : {1'b0, row0};
      end_walk = row1 >= {1'b0, geom.height};
      emit     = !done0 && !empty && !end_walk;

      x  = wrap ? '0 : col0;
      y  = row1[DW-1:0];
      ov = {1'b0, geom.overlap};

      rem_w = geom.width - x;
      rem_h = geom.height - y;
      cw    = (geom.tile < rem_w) ? geom.tile : rem_w;
      ch    = (geom.tile < rem_h) ? geom.tile : rem_h;
      ex    = (x > ov) ? x - ov : '0;
      ey    = (y > ov) ? y - ov : '0;

      er_sum = {1'b0, x} + {1'b0, cw} + {1'b0, ov};
      eb_sum = {1'b0, y} + {1'b0, ch} + {1'b0, ov};
      er     = (er_sum < {1'b0, geom.width})  ? er_sum[DW-1:0] : geom.width;
      eb     = (eb_sum < {1'b0, geom.height}) ? eb_sum[DW-1:0] : geom.height;

      nxt_col   = {1'b0, x} + {1'b0, geom.tile};
      nxt_row   = {1'b0, y} + {1'b0, geom.tile};
      next_wrap = nxt_col >= {1'b0, geom.width};
      last      = next_wrap && (nxt_row >= {1'b0, geom.height});

      col_in  = col_ff;
      row_in  = row_ff;
      done_in = done_ff;
      if (fire) begin
         if (emit) begin
            col_in  = next_wrap ? '0 : nxt_col[DW-1:0];
            row_in  = next_wrap ? nxt_row[DW-1:0] : y;
            done_in = last;
         end else begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         done_ff <= 1'b1;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      desc.core_x      = x[otw_pkg::POS_W-1:0];
      desc.core_y      = y[otw_pkg::POS_W-1:0];
      desc.core_cols   = cw;
      desc.core_rows   = ch;
      desc.ext_x       = ex[otw_pkg::POS_W-1:0];
      desc.ext_y       = ey[otw_pkg::POS_W-1:0];
      desc.ext_width   = er - ex;
      desc.ext_height  = eb - ey;
      desc.last_tile   = last;

      status.emit      = emit;
      status.walk_done = done_ff;
   end

endmodule

// ----- sim/otw_checker.sv -----
// otw_checker: watches the request, result and register ports of the tile walker,
// predicts each tile descriptor and compares it with what the block returns
// depends on otw_pkg
`timescale 1ns / 1ps

module otw_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_restart,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [otw_pkg::POS_W-1:0]      rsp_core_x,
   input  logic [otw_pkg::POS_W-1:0]      rsp_core_y,
   input  logic [otw_pkg::DIM_W-1:0]      rsp_core_cols,
   input  logic [otw_pkg::DIM_W-1:0]      rsp_core_rows,
   input  logic [otw_pkg::POS_W-1:0]      rsp_ext_x,
   input  logic [otw_pkg::POS_W-1:0]      rsp_ext_y,
   input  logic [otw_pkg::DIM_W-1:0]      rsp_ext_width,
   input  logic [otw_pkg::DIM_W-1:0]      rsp_ext_height,
   input  logic                           rsp_last_tile,
   input  logic                           csr_wr_en,
   input  logic [otw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [otw_pkg::DIM_W-1:0]      csr_wdata,
   output int                             fail_count,
   output int                             pending,
   output int                             tiles_checked
);

   int unsigned cfg_width, cfg_height, cfg_tile, cfg_overlap;
   int unsigned next_col, next_row;
   bit walk_finished;
   otw_pkg::desc_type expected_tiles[$];
   otw_pkg::desc_type want;
   bit bad;

   function automatic bit next_tile_descriptor(input bit restart,
                                               output otw_pkg::desc_type d);
      int unsigned w, h, big, tile, ov, x, y, cw, ch, ex, ey, er, eb;
      d = '0;
      w = (cfg_width > otw_pkg::MAX_DIM) ? otw_pkg::MAX_DIM : cfg_width;
      h = (cfg_height > otw_pkg::MAX_DIM) ? otw_pkg::MAX_DIM : cfg_height;
      if (restart) begin
         next_col = 0;
         next_row = 0;
         walk_finished = 1'b0;
      end
      if (walk_finished) return 1'b0;
      if (w == 0 || h == 0) begin
         walk_finished = 1'b1;
         return 1'b0;
      end
      big = (w > h) ? w : h;
      if (big < otw_pkg::MIN_TILE) begin
         tile = big;
      end else begin
         tile = (cfg_tile < otw_pkg::MIN_TILE) ? otw_pkg::MIN_TILE : cfg_tile;
         if (tile > big) tile = big;
      end
      ov = (cfg_overlap < tile / 2) ? cfg_overlap : tile / 2;
      // registers may have changed since the last tile
      if (next_col >= w) begin
         next_col = 0;
         next_row = next_row + tile;
      end
      if (next_row >= h) begin
         walk_finished = 1'b1;
         return 1'b0;
      end
      x = next_col;
      y = next_row;
      cw = (tile < w - x) ? tile : w - x;
      ch = (tile < h - y) ? tile : h - y;
      ex = (x > ov) ? x - ov : 0;
      ey = (y > ov) ? y - ov : 0;
      er = (w < x + cw + ov) ? w : x + cw + ov;
      eb = (h < y + ch + ov) ? h : y + ch + ov;
      next_col = x + tile;
      if (next_col >= w) begin
         next_col = 0;
         next_row = y + tile;
         if (next_row >= h) begin
            d.last_tile = 1'b1;
            walk_finished = 1'b1;
         end
      end
      next_col = next_col & 32'h1FFF;
      next_row = next_row & 32'h1FFF;
      d.core_x      = x[otw_pkg::POS_W-1:0];
      d.core_y      = y[otw_pkg::POS_W-1:0];
      d.core_cols   = cw[otw_pkg::DIM_W-1:0];
      d.core_rows   = ch[otw_pkg::DIM_W-1:0];
      d.ext_x       = ex[otw_pkg::POS_W-1:0];
      d.ext_y       = ey[otw_pkg::POS_W-1:0];
      d.ext_width   = otw_pkg::DIM_W'(er - ex);
      d.ext_height  = otw_pkg::DIM_W'(eb - ey);
      return 1'b1;
   endfunction

   function automatic bit field_differs(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
      if (exp_val == act_val) return 1'b0;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_width = 0;
         cfg_height = 0;
         cfg_tile = 32'(otw_pkg::TILE_RESET);
         cfg_overlap = 0;
         next_col = 0;
         next_row = 0;
         walk_finished = 1'b1;
         expected_tiles.delete();
         fail_count <= 0;
         pending <= 0;
         tiles_checked <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               otw_pkg::REG_IMAGE_WIDTH:       cfg_width = 32'(csr_wdata);
               otw_pkg::REG_IMAGE_HEIGHT:      cfg_height = 32'(csr_wdata);
               otw_pkg::REG_REQUESTED_TILE:    cfg_tile = 32'(csr_wdata);
               otw_pkg::REG_REQUESTED_OVERLAP: cfg_overlap = 32'(csr_wdata);
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_tiles.size() == 0) begin
               $display("%0t: unexpected result transaction, expected none, got core %0d,%0d",
                        $time, rsp_core_x, rsp_core_y);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_tiles.pop_front();
               bad = 1'b0;
               bad |= field_differs("core_x", 32'(want.core_x), 32'(rsp_core_x));
               bad |= field_differs("core_y", 32'(want.core_y), 32'(rsp_core_y));
               bad |= field_differs("core_cols", 32'(want.core_cols), 32'(rsp_core_cols));
               bad |= field_differs("core_rows", 32'(want.core_rows), 32'(rsp_core_rows));
               bad |= field_differs("ext_x", 32'(want.ext_x), 32'(rsp_ext_x));
               bad |= field_differs("ext_y", 32'(want.ext_y), 32'(rsp_ext_y));
               bad |= field_differs("ext_width", 32'(want.ext_width), 32'(rsp_ext_width));
               bad |= field_differs("ext_height", 32'(want.ext_height),
                                    32'(rsp_ext_height));
               bad |= field_differs("last_tile", 32'(want.last_tile), 32'(rsp_last_tile));
               if (bad) fail_count <= fail_count + 1;
               tiles_checked <= tiles_checked + 1;
            end
         end
         if (req_valid && req_ready) begin
            if (next_tile_descriptor(req_restart, want)) begin
               expected_tiles.insert(expected_tiles.size(), want);
            end
         end
         pending <= expected_tiles.size();
      end
   end

endmodule

// ----- sim/testbench.sv -----
// testbench: clock, reset, request and register stimulus and verdict for the tile walker
// depends on otw_pkg, overlapped_tile_walker_unit and otw_checker
`timescale 1ns / 1ps

module testbench;

   localparam int ITEM_TARGET = 1600;
   localparam int CALM_FROM   = 1400;
   localparam int STALL_LIMIT = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_restart = 1'b0;
   logic rsp_ready = 1'b0;
   logic csr_wr_en = 1'b0;
   logic [otw_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [otw_pkg::DIM_W-1:0] csr_wdata = '0;
   logic req_ready, rsp_valid, rsp_last_tile;
   logic [otw_pkg::POS_W-1:0] rsp_core_x, rsp_core_y, rsp_ext_x, rsp_ext_y;
   logic [otw_pkg::DIM_W-1:0] rsp_core_cols, rsp_core_rows, rsp_ext_width, rsp_ext_height;
   logic calm = 1'b0;

   int fail_count, pending, tiles_checked;
   int requests_sent = 0;
   int geometries = 0;
   int stall_left = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   overlapped_tile_walker_unit dut (.*);

   otw_checker tile_check (.*);

   // result side back-pressure in short bursts
   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_request(input logic restart);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(input otw_pkg::csr_index_type idx,
                            input logic [otw_pkg::DIM_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // drain, let the pipeline clear with no request, then load new geometry
   task automatic set_geometry(input int w, input int h, input int t, input int o);
      wait_results();
      repeat (6) @(posedge clock);
      write_reg(otw_pkg::REG_IMAGE_WIDTH, otw_pkg::DIM_W'(w));
      write_reg(otw_pkg::REG_IMAGE_HEIGHT, otw_pkg::DIM_W'(h));
      write_reg(otw_pkg::REG_REQUESTED_TILE, otw_pkg::DIM_W'(t));
      write_reg(otw_pkg::REG_REQUESTED_OVERLAP, otw_pkg::DIM_W'(o));
      csr_wr_en <= 1'b0;
      @(posedge clock);
      geometries++;
   endtask

   initial begin
      int n, w, h, t, o;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty image straight after reset
      send_request(1'b1);
      send_request(1'b0);
      // 3 x 2 tiles, overlap above half the tile, one request past the end
      set_geometry(130, 70, 64, 40);
      send_request(1'b1);
      repeat (6) send_request(1'b0);
      // oversized sides, tile and overlap
      set_geometry(8191, 40, 8191, 8191);
      send_request(1'b1);
      send_request(1'b0);
      // image smaller than the minimum tile
      set_geometry(1, 1, 0, 0);
      send_request(1'b1);
      repeat (2) send_request(1'b0);
      set_geometry(4096, 4096, 4096, 4096);
      send_request(1'b1);
      // geometry shrinks under a walk in progress
      set_geometry(300, 100, 64, 0);
      send_request(1'b1);
      repeat (4) send_request(1'b0);
      set_geometry(200, 100, 64, 0);
      send_request(1'b0);
      set_geometry(200, 50, 64, 0);
      send_request(1'b0);

      while (requests_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               w = $urandom_range(1, 400);
               h = $urandom_range(1, 400);
               t = $urandom_range(0, 300);
               o = $urandom_range(0, 200);
            end
            4, 5: begin
               w = $urandom_range(1, 63);
               h = $urandom_range(1, 63);
               t = $urandom_range(0, 4096);
               o = $urandom_range(0, 64);
            end
            6, 7: begin
               w = $urandom_range(0, 4096);
               h = $urandom_range(0, 4096);
               t = $urandom_range(0, 4096);
               o = $urandom_range(0, 4096);
            end
            8: begin
               w = ($urandom_range(0, 1) == 0) ? 0 : 4096;
               h = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4096) : 4096;
               t = ($urandom_range(0, 1) == 0) ? 64 : 4096;
               o = $urandom_range(0, 4096);
            end
            default: begin
               w = $urandom_range(0, 8191);
               h = $urandom_range(0, 8191);
               t = $urandom_range(0, 8191);
               o = $urandom_range(0, 8191);
            end
         endcase
         set_geometry(w, h, t, o);
         n = $urandom_range(1, 60);
         send_request($urandom_range(0, 4) != 0);
         repeat (n - 1) begin
            if (!calm && $urandom_range(0, 99) == 0) wait_results();
            send_request($urandom_range(0, 39) == 0);
         end
         if (requests_sent >= CALM_FROM) calm <= 1'b1;
      end

      wait_results();
      repeat (10) @(posedge clock);
      $display("%0d request transactions over %0d geometries, %0d tile descriptors compared",
               requests_sent, geometries, tiles_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
